### hw/rtl/slipdec_pkg.sv
// Shared types and constants for the SLIP frame decoder.
`default_nettype none
package slipdec_pkg;

    localparam int FRAME_LEN_MAX = 4096;
    localparam int RAW_LEN_MAX   = 8192;

    localparam int DCNT_W     = $clog2(FRAME_LEN_MAX + 1);
    localparam int RCNT_W     = $clog2(RAW_LEN_MAX + 1);
    localparam int CFG_DATA_W = (DCNT_W > RCNT_W) ? DCNT_W : RCNT_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_LIMIT     = 1'd1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BYTE = 2'd1,
        PH_ESC  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_DONE      = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_RAW_LIMIT = 3'd3,
        ST_BAD_ESC   = 3'd4
    } status_t;

    typedef struct packed {
        phase_t              phase;
        logic [DCNT_W-1:0]   data_count;
        logic [RCNT_W-1:0]   raw_count;
    } slip_state_t;

    typedef struct packed {
        logic                emit;
        logic [7:0]          data_byte;
        status_t             status;
        logic [DCNT_W-1:0]   frame_len;
    } slip_result_t;

endpackage
`default_nettype wire

### hw/rtl/slip_frame_decoder.sv
// SLIP frame decoder top level: input register, state, and result register.
// An accepted byte is held in the input register; its result is loaded into the
// result register once that register is free or draining.
// Throughput: one byte per cycle unless out_ready stalls; step logic is combinational.
// A byte that yields no result produces no output transaction.
// Reset clears the hunt state and both counters and restores the limits
// to 4096 decoded bytes and 8192 raw bytes.
`default_nettype none
module slip_frame_decoder
    import slipdec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            line_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 data_byte,
    output logic [2:0]                 status,
    output logic [DCNT_W-1:0]          frame_len
);

    logic [DCNT_W-1:0] max_frame_len_reg;
    logic [RCNT_W-1:0] raw_limit_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    slip_state_t       state_reg;
    slip_state_t       state_next;
    slip_result_t      res;
    logic              out_valid_reg;
    logic [7:0]        data_byte_reg;
    logic [2:0]        status_reg;
    logic [DCNT_W-1:0] frame_len_reg;
    logic              advance;

    // The held byte moves on whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg <= DCNT_W'(FRAME_LEN_MAX);
            raw_limit_reg     <= RCNT_W'(RAW_LEN_MAX);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data[DCNT_W-1:0];
                REG_RAW_LIMIT:     raw_limit_reg     <= cfg_data[RCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= line_byte;
        end
    end

    slipdec_step u_step (
        .cur           (state_reg),
        .line_byte     (in_byte_reg),
        .max_frame_len (max_frame_len_reg),
        .raw_limit     (raw_limit_reg),
        .nxt           (state_next),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_HUNT;
            state_reg.data_count <= '0;
            state_reg.raw_count  <= '0;
            out_valid_reg        <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= res.emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            data_byte_reg <= res.data_byte;
            status_reg    <= res.status;
            frame_len_reg <= res.frame_len;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign status    = status_reg;
    assign frame_len = frame_len_reg;

endmodule
`default_nettype wire

### hw/rtl/slipdec_step.sv
// Combinational next-state and result logic for one received line byte.
`default_nettype none
module slipdec_step
    import slipdec_pkg::*;
(
    input  wire slip_state_t        cur,
    input  wire logic [7:0]         line_byte,
    input  wire logic [DCNT_W-1:0]  max_frame_len,
    input  wire logic [RCNT_W-1:0]  raw_limit,
    output slip_state_t             nxt,
    output slip_result_t            res
);

    logic [DCNT_W-1:0] frame_cap;
    logic [RCNT_W-1:0] raw_cap;
    logic [RCNT_W-1:0] raw_inc;
    logic              have_data;
    logic              done;

    always_comb
    begin
        frame_cap = (max_frame_len > DCNT_W'(FRAME_LEN_MAX)) ? DCNT_W'(FRAME_LEN_MAX)
                                                              : max_frame_len;
        if (raw_limit > RCNT_W'(RAW_LEN_MAX))
            raw_cap = RCNT_W'(RAW_LEN_MAX);
        else if (raw_limit == '0)
            raw_cap = RCNT_W'(1);
        else
            raw_cap = raw_limit;
    end

    always_comb
    begin
        nxt           = cur;
        res.emit      = 1'b0;
        res.data_byte = 8'd0;
        res.status    = ST_DATA;
        res.frame_len = '0;
        have_data     = 1'b0;
        done          = 1'b0;

        // The raw count saturates so that it never wraps on a long hunt.
        raw_inc = (cur.raw_count < RCNT_W'(RAW_LEN_MAX)) ? cur.raw_count + RCNT_W'(1)
                                                          : cur.raw_count;
        nxt.raw_count = raw_inc;

        unique case (cur.phase)
            PH_BYTE:
            begin
                if (line_byte == SLIP_ESC)
                begin
                    nxt.phase = PH_ESC;
                end
                else if (line_byte == SLIP_END)
                begin
                    res.emit      = 1'b1;
                    done          = 1'b1;
                    res.status    = ST_DONE;
                    res.frame_len = cur.data_count;
                end
                else
                begin
                    have_data     = 1'b1;
                    res.data_byte = line_byte;
                end
            end
            PH_ESC:
            begin
                if (line_byte == SLIP_ESC_END)
                begin
                    have_data     = 1'b1;
                    res.data_byte = SLIP_END;
                    nxt.phase     = PH_BYTE;
                end
                else if (line_byte == SLIP_ESC_ESC)
                begin
                    have_data     = 1'b1;
                    res.data_byte = SLIP_ESC;
                    nxt.phase     = PH_BYTE;
                end
                else
                begin
                    res.emit   = 1'b1;
                    done       = 1'b1;
                    res.status = ST_BAD_ESC;
                end
            end
            PH_HUNT:
            begin
                nxt.phase = (line_byte == SLIP_END) ? PH_BYTE : PH_HUNT;
            end
            default:
            begin
                nxt.phase = PH_HUNT;
            end
        endcase

        if (have_data)
        begin
            res.emit = 1'b1;
            if (cur.data_count >= frame_cap)
            begin
                done          = 1'b1;
                res.status    = ST_TOO_LONG;
                res.data_byte = 8'd0;
            end
            else
            begin
                nxt.data_count = cur.data_count + DCNT_W'(1);
            end
        end

        // Any other terminating result on this byte takes precedence.
        if (!done && (raw_inc >= raw_cap))
        begin
            res.emit      = 1'b1;
            done          = 1'b1;
            res.status    = ST_RAW_LIMIT;
            res.data_byte = 8'd0;
        end

        if (done)
        begin
            nxt.phase      = PH_HUNT;
            nxt.data_count = '0;
            nxt.raw_count  = '0;
        end
    end

endmodule
`default_nettype wire
